// ===== design/assert_macros.svh =====
// Assertion macros shared by the filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define RCC_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define RCC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RCC_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== design/rcc_pkg.sv =====
// Types, constants and helpers of the 3x3 RGB convolution filter.
package rcc_pkg;

    localparam int MAX_WIDTH_DEFAULT = 2048;

    localparam int DIM_W  = 12;
    localparam int KROW_W = 24;
    localparam int PIX_W  = 24;
    localparam int CH_W   = 8;
    localparam int COL_W  = 11;
    localparam int ROW_W  = 12;
    localparam int IDX_W  = 3;
    localparam int PROD_W = 17;
    localparam int SUM_W  = 20;

    localparam int MIN_DIM  = 3;
    localparam int PIX_MAX  = 255;
    localparam int OUT_DEPTH = 8;

    localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 12'd480;
    localparam logic [KROW_W-1:0] KROW_TOP_RST     = 24'd0;
    localparam logic [KROW_W-1:0] KROW_MIDDLE_RST  = 24'd256;
    localparam logic [KROW_W-1:0] KROW_BOTTOM_RST  = 24'd0;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_KROW_TOP     = 3'd2;
    localparam logic [IDX_W-1:0] REG_KROW_MIDDLE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_KROW_BOTTOM  = 3'd4;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic             emit;
        logic [COL_W-1:0] centre_column;
        logic [ROW_W-1:0] centre_row;
        logic             last;
    } pos_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t lower;
        pixel_t cur;
    } col_t;

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [COL_W-1:0] centre_column;
        logic [ROW_W-1:0] centre_row;
        logic             last;
    } res_t;

    // signed coefficient sel of a kernel row, left one in the low byte
    function automatic logic signed [CH_W-1:0] coef(logic [KROW_W-1:0] row, logic [1:0] sel);
        logic signed [CH_W-1:0] c;
        c = $signed(row[CH_W*sel +: CH_W]);
        return c;
    endfunction

    // channel sel of a packed pixel, red in the low byte
    function automatic logic [CH_W-1:0] chan(pixel_t px, logic [1:0] sel);
        logic [CH_W-1:0] v;
        v = px[CH_W*sel +: CH_W];
        return v;
    endfunction

    function automatic logic [CH_W-1:0] clamp(logic signed [SUM_W-1:0] v);
        logic [CH_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > SUM_W'(PIX_MAX))
        begin
            r = CH_W'(PIX_MAX);
        end
        else
        begin
            r = v[CH_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/rcc_scan.sv =====
// Raster position tracking: column and row counters, border and frame end flags.
module rcc_scan #(
    parameter int MAX_WIDTH = rcc_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           acc,
    input  logic                           frame_start,
    input  logic [rcc_pkg::DIM_W-1:0]      frame_width,
    input  logic [rcc_pkg::DIM_W-1:0]      frame_height,
    output logic [$clog2(MAX_WIDTH)-1:0]   rd_idx,
    output rcc_pkg::pos_t                  pos
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > rcc_pkg::DIM_W) ? CW + 1 : rcc_pkg::DIM_W;
    localparam int HW = rcc_pkg::ROW_W + 1;

    logic [CW-1:0]             col_reg, col_next;
    logic [rcc_pkg::ROW_W-1:0] row_reg, row_next;

    logic [CW-1:0]             x;
    logic [rcc_pkg::ROW_W-1:0] y;
    logic [WW-1:0]             fw_ext, w_eff, x_ext, x_inc;
    logic [rcc_pkg::DIM_W-1:0] h_eff;
    logic [HW-1:0]             y_inc;

    always_comb
    begin
        x      = frame_start ? '0 : col_reg;
        y      = frame_start ? '0 : row_reg;
        fw_ext = WW'(frame_width);
        if (fw_ext > WW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else if (fw_ext < WW'(rcc_pkg::MIN_DIM))
        begin
            w_eff = WW'(rcc_pkg::MIN_DIM);
        end
        else
        begin
            w_eff = fw_ext;
        end
        h_eff = (frame_height < rcc_pkg::DIM_W'(rcc_pkg::MIN_DIM)) ?
                rcc_pkg::DIM_W'(rcc_pkg::MIN_DIM) : frame_height;

        x_ext = WW'(x);
        x_inc = x_ext + WW'(1);
        y_inc = HW'(y) + HW'(1);

        if (x_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (y_inc >= HW'(h_eff)) ? '0 : y_inc[rcc_pkg::ROW_W-1:0];
        end
        else
        begin
            col_next = x_inc[CW-1:0];
            row_next = y;
        end

        rd_idx            = x;
        pos.emit          = (x_ext >= WW'(2)) && (y >= rcc_pkg::ROW_W'(2));
        pos.centre_column = x_inc[rcc_pkg::COL_W-1:0] - rcc_pkg::COL_W'(2);
        pos.centre_row    = y - rcc_pkg::ROW_W'(1);
        pos.last          = (x_ext == w_eff - WW'(1)) &&
                            (y == h_eff - rcc_pkg::DIM_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== design/rcc_line_buf.sv =====
// Two-line store as one 48-bit memory: read on request, written back in the next cycle.
`include "assert_macros.svh"

module rcc_line_buf #(
    parameter int MAX_WIDTH = rcc_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         acc,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_idx,
    input  rcc_pkg::pixel_t              px,
    input  rcc_pkg::pos_t                pos_in,
    output logic                         s1_valid,
    output rcc_pkg::pos_t                s1_pos,
    output rcc_pkg::col_t                col
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = 2 * rcc_pkg::PIX_W;

    // entry layout: upper line in the top half, lower line in the bottom half
    logic [EW-1:0] mem [MAX_WIDTH];

    logic [EW-1:0]   rd_data_reg;
    logic [EW-1:0]   fwd_data_reg;
    logic            fwd_hit_reg;
    logic            s1_valid_reg;
    logic [CW-1:0]   s1_idx_reg;
    rcc_pkg::pixel_t s1_px_reg;
    rcc_pkg::pos_t   s1_pos_reg;

    logic [EW-1:0] entry;
    logic [EW-1:0] wdata;
    logic          hit;

    always_comb
    begin
        entry     = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        wdata     = {entry[rcc_pkg::PIX_W-1:0], s1_px_reg};
        col.upper = entry[EW-1:rcc_pkg::PIX_W];
        col.lower = entry[rcc_pkg::PIX_W-1:0];
        col.cur   = s1_px_reg;
        // back-to-back request to the entry being written this cycle
        hit       = acc && s1_valid_reg && (rd_idx == s1_idx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            mem[s1_idx_reg] <= wdata;
        end
        if (acc)
        begin
            rd_data_reg  <= mem[rd_idx];
            fwd_data_reg <= wdata;
            s1_idx_reg   <= rd_idx;
            s1_px_reg    <= px;
            s1_pos_reg   <= pos_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= acc;
            fwd_hit_reg  <= hit;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_pos   = s1_pos_reg;

    `RCC_ASSERT_IMPL(a_fwd_same_entry, clk, rst_n, fwd_hit_reg, s1_valid_reg && $past(s1_valid_reg) && ($past(s1_idx_reg) == s1_idx_reg))

endmodule

// ===== design/rcc_mac.sv =====
// 3x3 window, per-channel products, sum and clamp to 0..255.
module rcc_mac (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s1_valid,
    input  rcc_pkg::pos_t                s1_pos,
    input  rcc_pkg::col_t                col,
    input  logic [rcc_pkg::KROW_W-1:0]   kernel_row_top,
    input  logic [rcc_pkg::KROW_W-1:0]   kernel_row_middle,
    input  logic [rcc_pkg::KROW_W-1:0]   kernel_row_bottom,
    output logic                         push,
    output logic                         drop,
    output rcc_pkg::res_t                res
);

    rcc_pkg::pixel_t win_reg [6];
    logic            s2_valid_reg;
    rcc_pkg::pos_t   s2_pos_reg;
    logic signed [rcc_pkg::PROD_W-1:0] prod_reg [3][9];

    rcc_pkg::pixel_t             tap  [9];
    logic [rcc_pkg::KROW_W-1:0]  krow [3];
    logic signed [rcc_pkg::SUM_W-1:0] acc_sum [3];

    always_comb
    begin
        krow[0] = kernel_row_top;
        krow[1] = kernel_row_middle;
        krow[2] = kernel_row_bottom;
        // tap index is row*3 + column; the newest column comes straight from the store
        for (int r = 0; r < 3; r++)
        begin
            tap[r*3]     = win_reg[r];
            tap[r*3 + 1] = win_reg[3 + r];
        end
        tap[2] = col.upper;
        tap[5] = col.lower;
        tap[8] = col.cur;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        prod_reg[ch][r*3 + c] <=
                            rcc_pkg::coef(krow[r], 2'(c)) *
                            $signed({1'b0, rcc_pkg::chan(tap[r*3 + c], 2'(ch))});
                    end
                end
            end
            s2_pos_reg <= s1_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            s2_valid_reg <= s1_valid;
            if (s1_valid)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r] <= win_reg[3 + r];
                end
                win_reg[3] <= col.upper;
                win_reg[4] <= col.lower;
                win_reg[5] <= col.cur;
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            acc_sum[ch] = '0;
            for (int k = 0; k < 9; k++)
            begin
                acc_sum[ch] = acc_sum[ch] + rcc_pkg::SUM_W'(prod_reg[ch][k]);
            end
        end
        res.red           = rcc_pkg::clamp(acc_sum[0]);
        res.green         = rcc_pkg::clamp(acc_sum[1]);
        res.blue          = rcc_pkg::clamp(acc_sum[2]);
        res.centre_column = s2_pos_reg.centre_column;
        res.centre_row    = s2_pos_reg.centre_row;
        res.last          = s2_pos_reg.last;
        push              = s2_valid_reg && s2_pos_reg.emit;
        drop              = s2_valid_reg && !s2_pos_reg.emit;
    end

endmodule

// ===== design/rcc_out_fifo.sv =====
// Result queue with a credit count covering every request still in the pipeline.
`include "assert_macros.svh"

module rcc_out_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          acc,
    input  logic          push,
    input  logic          drop,
    input  rcc_pkg::res_t wdata,
    input  logic          res_stall,
    output logic          res_valid,
    output rcc_pkg::res_t rdata,
    output logic          full
);

    localparam int DEPTH = rcc_pkg::OUT_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int TW    = $clog2(DEPTH + 1);

    rcc_pkg::res_t q_reg [DEPTH];
    logic [PW:0]   wr_ptr_reg, rd_ptr_reg;
    logic [TW-1:0] tok_reg, tok_next;
    logic [PW:0]   occ;
    logic          pop;

    always_comb
    begin
        occ       = wr_ptr_reg - rd_ptr_reg;
        res_valid = (occ != '0);
        pop       = res_valid && !res_stall;
        rdata     = q_reg[rd_ptr_reg[PW-1:0]];
        tok_next  = tok_reg + TW'(acc) - TW'(drop) - TW'(pop);
        full      = (tok_reg == TW'(DEPTH));
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg[PW-1:0]] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + (PW+1)'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + (PW+1)'(1);
            end
            tok_reg <= tok_next;
        end
    end

    `RCC_ASSERT_NEVER(a_push_full, clk, rst_n, push && (occ == (PW+1)'(DEPTH)))
    `RCC_ASSERT_NEVER(a_credit_cover, clk, rst_n, TW'(occ) > tok_reg)

endmodule

// ===== design/rgb_conv3x3_clamp.sv =====
// Top level of the streaming 3x3 RGB convolution filter.
// Takes one RGB pixel per clock in raster order while pix_stall is low and returns, for every
// interior pixel, the three channels convolved with the signed 3x3 kernel and clamped to 0..255,
// with the centre column and row and a flag on the last interior pixel of the frame; the one-pixel
// border gives no result. Sustained rate is one pixel per clock when not stalled, set by the single
// line memory that is read on each request and written back the next cycle (a back-to-back hit on
// the same entry is forwarded). Up to eight requests may be in flight or queued, so short stalls on
// the result side do not stop the input. The line memory holds no reset value and needs no clearing
// pass; configure only while the block is idle.
module rgb_conv3x3_clamp #(
    parameter int MAX_WIDTH = rcc_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rcc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [rcc_pkg::KROW_W-1:0]    cfg_data,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  logic [rcc_pkg::CH_W-1:0]      red_in,
    input  logic [rcc_pkg::CH_W-1:0]      green_in,
    input  logic [rcc_pkg::CH_W-1:0]      blue_in,
    input  logic                          frame_start,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [rcc_pkg::CH_W-1:0]      red_out,
    output logic [rcc_pkg::CH_W-1:0]      green_out,
    output logic [rcc_pkg::CH_W-1:0]      blue_out,
    output logic [rcc_pkg::COL_W-1:0]     centre_column,
    output logic [rcc_pkg::ROW_W-1:0]     centre_row,
    output logic                          frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [rcc_pkg::DIM_W-1:0]  frame_width_reg;
    logic [rcc_pkg::DIM_W-1:0]  frame_height_reg;
    logic [rcc_pkg::KROW_W-1:0] krow_top_reg;
    logic [rcc_pkg::KROW_W-1:0] krow_middle_reg;
    logic [rcc_pkg::KROW_W-1:0] krow_bottom_reg;

    logic            acc;
    logic [CW-1:0]   rd_idx;
    rcc_pkg::pos_t   pos;
    rcc_pkg::pixel_t px;
    logic            s1_valid;
    rcc_pkg::pos_t   s1_pos;
    rcc_pkg::col_t   col;
    logic            push, drop;
    rcc_pkg::res_t   res_w;
    rcc_pkg::res_t   res_q;

    assign cfg_ready = 1'b1;
    assign acc       = pix_valid && !pix_stall;
    assign px        = {blue_in, green_in, red_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= rcc_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= rcc_pkg::FRAME_HEIGHT_RST;
            krow_top_reg     <= rcc_pkg::KROW_TOP_RST;
            krow_middle_reg  <= rcc_pkg::KROW_MIDDLE_RST;
            krow_bottom_reg  <= rcc_pkg::KROW_BOTTOM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rcc_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[rcc_pkg::DIM_W-1:0];
                rcc_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[rcc_pkg::DIM_W-1:0];
                rcc_pkg::REG_KROW_TOP:     krow_top_reg     <= cfg_data;
                rcc_pkg::REG_KROW_MIDDLE:  krow_middle_reg  <= cfg_data;
                rcc_pkg::REG_KROW_BOTTOM:  krow_bottom_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    rcc_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc          (acc),
        .frame_start  (frame_start),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .rd_idx       (rd_idx),
        .pos          (pos)
    );

    rcc_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc      (acc),
        .rd_idx   (rd_idx),
        .px       (px),
        .pos_in   (pos),
        .s1_valid (s1_valid),
        .s1_pos   (s1_pos),
        .col      (col)
    );

    rcc_mac u_mac (
        .clk               (clk),
        .rst_n             (rst_n),
        .s1_valid          (s1_valid),
        .s1_pos            (s1_pos),
        .col               (col),
        .kernel_row_top    (krow_top_reg),
        .kernel_row_middle (krow_middle_reg),
        .kernel_row_bottom (krow_bottom_reg),
        .push              (push),
        .drop              (drop),
        .res               (res_w)
    );

    rcc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .push      (push),
        .drop      (drop),
        .wdata     (res_w),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .rdata     (res_q),
        .full      (pix_stall)
    );

    assign red_out       = res_q.red;
    assign green_out     = res_q.green;
    assign blue_out      = res_q.blue;
    assign centre_column = res_q.centre_column;
    assign centre_row    = res_q.centre_row;
    assign frame_last    = res_q.last;

endmodule

// ===== tb/sv/tb_rgb_conv3x3_clamp.sv =====
// Self-checking testbench for the 3x3 RGB convolution filter: directed and random pixel streams vs. a local predictor.
module tb_rgb_conv3x3_clamp;
    import rcc_pkg::*;

    localparam int MAX_W         = MAX_WIDTH_DEFAULT;
    localparam int RANDOM_PIXELS = 1026;
    localparam int SETTLE_CYCLES = 16;
    localparam int HANG_LIMIT    = 2000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic            sof;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_req_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index   = '0;
    logic [KROW_W-1:0]   cfg_data    = '0;
    logic                pix_valid   = 1'b0;
    logic                pix_stall;
    logic [CH_W-1:0]     red_in      = '0;
    logic [CH_W-1:0]     green_in    = '0;
    logic [CH_W-1:0]     blue_in     = '0;
    logic                frame_start = 1'b0;
    logic                res_valid;
    logic                res_stall   = 1'b0;
    logic [CH_W-1:0]     red_out;
    logic [CH_W-1:0]     green_out;
    logic [CH_W-1:0]     blue_out;
    logic [COL_W-1:0]    centre_column;
    logic [ROW_W-1:0]    centre_row;
    logic                frame_last;

    // predictor copy of the block
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [KROW_W-1:0]   kern_row [3];
    pixel_t              upper_line [MAX_W];
    pixel_t              lower_line [MAX_W];
    pixel_t              window [6];
    int                  col_pos;
    int                  row_pos;

    res_t                filtered_due [$];
    res_t                want_res;
    rgb_req_t            pixel_backlog [$];
    rgb_req_t            on_wire;
    int                  pix_pushed   = 0;
    int                  pix_taken    = 0;
    int                  mismatches   = 0;
    int                  idle_pct     = 0;
    int                  stall_pct    = 0;
    int                  quiet_cycles = 0;

    rgb_conv3x3_clamp u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .frame_start   (frame_start),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .centre_column (centre_column),
        .centre_row    (centre_row),
        .frame_last    (frame_last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Advances the filter model by one pixel and queues the result it produces, if any.
    function automatic void convolve_step(input rgb_req_t req);
        int w, h, x, y, acc, kv, pv;
        pixel_t px;
        pixel_t tap [3];
        pixel_t p;
        logic signed [CH_W-1:0] k;
        logic [CH_W-1:0] level [3];
        res_t res;
        w = int'(width_reg);
        h = int'(height_reg);
        if (w > MAX_W)
            w = MAX_W;
        if (w < MIN_DIM)
            w = MIN_DIM;
        if (h < MIN_DIM)
            h = MIN_DIM;
        if (req.sof)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        x = col_pos;
        y = row_pos;
        px = {req.blue, req.green, req.red};
        tap[0] = upper_line[x];
        tap[1] = lower_line[x];
        tap[2] = px;
        upper_line[x] = tap[1];
        lower_line[x] = px;
        if (x >= 2 && y >= 2)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                acc = 0;
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        p = (c < 2) ? window[c*3 + r] : tap[r];
                        k = kern_row[r][CH_W*c +: CH_W];
                        kv = k;
                        pv = p[CH_W*ch +: CH_W];
                        acc += kv * pv;
                    end
                end
                if (acc < 0)
                    level[ch] = '0;
                else if (acc > PIX_MAX)
                    level[ch] = CH_W'(PIX_MAX);
                else
                    level[ch] = CH_W'(acc);
            end
            res.red           = level[0];
            res.green         = level[1];
            res.blue          = level[2];
            res.centre_column = COL_W'(x - 1);
            res.centre_row    = ROW_W'(y - 1);
            res.last          = (x == w - 1) && (y == h - 1);
            filtered_due.push_back(res);
        end
        for (int r = 0; r < 3; r++)
        begin
            window[r]     = window[3 + r];
            window[3 + r] = tap[r];
        end
        if (x + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : ((y + 1) & 12'hFFF);
        end
        else
        begin
            col_pos = x + 1;
        end
    endfunction

    // pixel request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid <= 1'b0;
        end
        else
        begin
            if (pix_valid && !pix_stall)
            begin
                convolve_step(on_wire);
                pix_taken <= pix_taken + 1;
            end
            if (!pix_valid || !pix_stall)
            begin
                if (pixel_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    on_wire = pixel_backlog.pop_front();
                    red_in      <= on_wire.red;
                    green_in    <= on_wire.green;
                    blue_in     <= on_wire.blue;
                    frame_start <= on_wire.sof;
                    pix_valid   <= 1'b1;
                end
                else
                begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (filtered_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: col %0d row %0d rgb %0d %0d %0d",
                                 centre_column, centre_row, red_out, green_out, blue_out);
                end
                else
                begin
                    want_res = filtered_due.pop_front();
                    if (red_out !== want_res.red || green_out !== want_res.green ||
                        blue_out !== want_res.blue ||
                        centre_column !== want_res.centre_column ||
                        centre_row !== want_res.centre_row || frame_last !== want_res.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("mismatch exp: rgb %0d %0d %0d col %0d row %0d last %0b",
                                     want_res.red, want_res.green, want_res.blue,
                                     want_res.centre_column, want_res.centre_row, want_res.last);
                            $display("         got: rgb %0d %0d %0d col %0d row %0d last %0b",
                                     red_out, green_out, blue_out,
                                     centre_column, centre_row, frame_last);
                        end
                    end
                end
            end
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // hang detector: no request moved on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_valid && !pix_stall) || (res_valid && !res_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [CH_W-1:0] rand_level();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return CH_W'($urandom_range(255));
    endfunction

    function automatic logic [KROW_W-1:0] rand_krow();
        logic [KROW_W-1:0] row;
        for (int c = 0; c < 3; c++)
        begin
            case ($urandom_range(7))
                0: row[CH_W*c +: CH_W] = 8'h80;
                1: row[CH_W*c +: CH_W] = 8'h7F;
                2: row[CH_W*c +: CH_W] = 8'h00;
                3: row[CH_W*c +: CH_W] = CH_W'($urandom_range(4));
                4: row[CH_W*c +: CH_W] = CH_W'(-$urandom_range(4, 1));
                default: row[CH_W*c +: CH_W] = CH_W'($urandom_range(255));
            endcase
        end
        return row;
    endfunction

    // sender idle / receiver stall percentages per stretch of the run
    task automatic set_pace(input int stretch);
        case (stretch)
            0:
            begin
                idle_pct  <= 23;
                stall_pct <= 82;
            end
            1:
            begin
                idle_pct  <= 82;
                stall_pct <= 23;
            end
            default:
            begin
                idle_pct  <= 0;
                stall_pct <= 0;
            end
        endcase
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write of a batch
    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [KROW_W-1:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            REG_FRAME_WIDTH:  width_reg   = data[DIM_W-1:0];
            REG_FRAME_HEIGHT: height_reg  = data[DIM_W-1:0];
            REG_KROW_TOP:     kern_row[0] = data;
            REG_KROW_MIDDLE:  kern_row[1] = data;
            REG_KROW_BOTTOM:  kern_row[2] = data;
            default: ;
        endcase
    endtask

    task automatic configure(input int w, input int h, input logic [KROW_W-1:0] k_top,
                             input logic [KROW_W-1:0] k_mid, input logic [KROW_W-1:0] k_bot);
        write_reg(REG_FRAME_WIDTH, KROW_W'(w));
        write_reg(REG_FRAME_HEIGHT, KROW_W'(h));
        write_reg(REG_KROW_TOP, k_top);
        write_reg(REG_KROW_MIDDLE, k_mid);
        write_reg(REG_KROW_BOTTOM, k_bot);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_pixel(input logic sof, input logic [CH_W-1:0] r,
                              input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
        rgb_req_t req;
        req.sof   = sof;
        req.red   = r;
        req.green = g;
        req.blue  = b;
        pixel_backlog.push_back(req);
        pix_pushed++;
    endtask

    // every stream opens a fresh frame so no result uses a line entry not written in that frame
    task automatic stream_pixels(input int count);
        for (int i = 0; i < count; i++)
            push_pixel(i == 0 || $urandom_range(63) == 0, rand_level(), rand_level(), rand_level());
    endtask

    // wait until all pixels are taken and all results are back, then let the pipe settle
    task automatic drain_pipe();
        while (pix_taken != pix_pushed)
            @(posedge clk);
        while (filtered_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int random_done;
        int phase;
        int w;
        int h;
        int n;
        random_done = 0;
        phase       = 0;
        width_reg   = FRAME_WIDTH_RST;
        height_reg  = FRAME_HEIGHT_RST;
        kern_row[0] = KROW_TOP_RST;
        kern_row[1] = KROW_MIDDLE_RST;
        kern_row[2] = KROW_BOTTOM_RST;
        for (int i = 0; i < MAX_W; i++)
        begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            window[i] = '0;
        col_pos = 0;
        row_pos = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 4x3 frame with extreme coefficients, then a second frame reached by
        // wrapping the counters instead of frame_start
        set_pace(0);
        configure(4, 3, 24'h7F807F, 24'h80FF01, 24'h0001FF);
        for (int i = 0; i < 24; i++)
            push_pixel(i == 0, (i % 2) ? 8'hFF : 8'h00, (i % 4 < 2) ? 8'hFF : 8'h00,
                       CH_W'(i * 37));
        drain_pipe();

        while (random_done < RANDOM_PIXELS)
        begin
            set_pace(random_done * 3 / RANDOM_PIXELS);
            if (phase == 2 || phase == 9)
            begin
                // widest line, once in range and once clipped to the line memory depth;
                // the stream covers only the start of the first line
                w = (phase == 2) ? MAX_W : 4095;
                h = $urandom_range(3, 0);
                n = $urandom_range(120, 60);
            end
            else if (phase == 6)
            begin
                w = $urandom_range(5, 3);
                h = 4095;
                n = 150;
            end
            else
            begin
                case ($urandom_range(9))
                    0:       w = $urandom_range(2, 0);
                    1, 2:    w = $urandom_range(40, 11);
                    default: w = $urandom_range(10, 3);
                endcase
                h = ($urandom_range(7) < 6) ? $urandom_range(6, 0) : $urandom_range(20, 7);
                n = $urandom_range(120, 20);
            end
            if (n > RANDOM_PIXELS - random_done)
                n = RANDOM_PIXELS - random_done;
            random_done += n;
            configure(w, h, rand_krow(), rand_krow(), rand_krow());
            stream_pixels(n);
            drain_pipe();
            phase++;
        end

        if (mismatches == 0 && filtered_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/rcc_pkg.sv
design/rcc_scan.sv
design/rcc_line_buf.sv
design/rcc_mac.sv
design/rcc_out_fifo.sv
design/rgb_conv3x3_clamp.sv
tb/sv/tb_rgb_conv3x3_clamp.sv
